// ===== design/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round table shared by the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [0:7][31:0]  t_vars;
    typedef logic [0:15][31:0] t_sched;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_UPDATE,
        S_EMIT
    } t_state;

    // control for one pass through the round unit
    typedef struct packed {
        logic  mem_word;   // message word comes from the block buffer
        t_word k;          // round constant
    } t_rnd_ctl;

    localparam int BUF_WORDS = 16;
    localparam int BUF_AW    = 4;

    localparam logic       ACT_ABSORB  = 1'b0;
    localparam logic       ACT_FINISH  = 1'b1;

    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam logic [5:0]  LEN_POS     = 6'd56;
    localparam logic [5:0]  FILL_LAST   = 6'd63;
    localparam logic [63:0] BLOCK_BITS  = 64'd512;
    localparam logic [3:0]  LEN_HI_WORD = 4'd14;
    localparam logic [3:0]  LEN_LO_WORD = 4'd15;
    localparam logic [5:0]  RND_LAST    = 6'd63;
    localparam logic [2:0]  WORD_LAST   = 3'd7;

    localparam t_vars IV = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== design/sha_in_if.sv =====
// ----------------------------------------------------------------------------
// sha_in_if
// Input channel: one item absorbs a message byte or finishes the message.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// ===== design/sha_out_if.sv =====
// ----------------------------------------------------------------------------
// sha_out_if
// Output channel: one item carries one digest word.
// ----------------------------------------------------------------------------
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        last_word;

    modport source (output valid, output word_index, output digest_word,
                    output last_word, input ready);
    modport sink   (input valid, input word_index, input digest_word,
                    input last_word, output ready);
endinterface

// ===== design/sha_ram.sv =====
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/sha_round.sv =====
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 round: message schedule word and working variable update.
// ----------------------------------------------------------------------------
module sha_round import sha_pkg::*; (
    input  t_vars    i_vars,
    input  t_sched   i_sched,
    input  t_word    i_mem_word,
    input  t_rnd_ctl i_ctl,
    output t_vars    o_vars,
    output t_word    o_w
);

    function automatic t_word bsig0(t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word bsig1(t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word ssig0(t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    t_word w_sched;
    t_word t1;
    t_word t2;
    t_word ch;
    t_word maj;

    // window slot 15 holds w[r-1], slot 0 holds w[r-16]
    assign w_sched = ssig1(i_sched[14]) + i_sched[9] + ssig0(i_sched[1]) + i_sched[0];
    assign o_w     = i_ctl.mem_word ? i_mem_word : w_sched;

    assign ch  = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
    assign maj = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^ (i_vars[1] & i_vars[2]);
    assign t1  = i_vars[7] + bsig1(i_vars[4]) + ch + i_ctl.k + o_w;
    assign t2  = bsig0(i_vars[0]) + maj;

    assign o_vars = '{t1 + t2, i_vars[0], i_vars[1], i_vars[2],
                      i_vars[3] + t1, i_vars[4], i_vars[5], i_vars[6]};

endmodule

// ===== design/sha256_hash.sv =====
// ----------------------------------------------------------------------------
// sha256_hash
// Byte-serial SHA-256 engine with a 16-word block buffer and one round unit.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    action, data_byte
//  o_out    out  valid/ready    word_index, digest_word, last_word
//
//  Absorb: one byte per cycle while idle; the 64th byte starts a busy phase
//  (load, 64 rounds on the shared round unit, chain update). Finish: pad
//  words fill/4 to 15 and a busy phase; a fill of 56 or more adds a pad
//  block, busy again. Then eight output items, one per cycle while ready.
//  Reset (synchronous) restores the initial hash and clears counts; the
//  buffer RAM is not cleared. i_in.ready is low while busy or emitting.
// ----------------------------------------------------------------------------
module sha256_hash import sha_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sha_in_if.sink         i_in,
    sha_out_if.source      o_out
);

    t_state      r_state;
    t_state      n_state;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_total;
    logic [23:0] r_acc;
    t_vars       r_chain;
    t_vars       r_vars;
    t_sched      r_sched;
    logic [5:0]  r_rnd;
    logic [3:0]  r_pad_idx;
    logic        r_part;
    logic        r_len_ok;
    logic        r_more;
    logic        r_final;
    logic [2:0]  r_out_idx;

    logic        in_acc;
    logic        out_acc;
    t_word       part_word;
    t_word       pad_word;

    logic              ram_we;
    logic [BUF_AW-1:0] ram_waddr;
    t_word             ram_wdata;
    logic [BUF_AW-1:0] ram_raddr;
    t_word             ram_rdata;

    t_rnd_ctl    rnd_ctl;
    t_vars       rnd_vars;
    t_word       rnd_w;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    // word holding the end of the message and the pad mark
    always_comb begin
        case (r_fill[1:0])
            2'd0:    part_word = {PAD_MARK, 24'h0};
            2'd1:    part_word = {r_acc[7:0], PAD_MARK, 16'h0};
            2'd2:    part_word = {r_acc[15:0], PAD_MARK, 8'h0};
            default: part_word = {r_acc[23:0], PAD_MARK};
        endcase
    end

    always_comb begin
        if (r_part) begin
            pad_word = part_word;
        end else if (r_len_ok && r_pad_idx == LEN_HI_WORD) begin
            pad_word = r_total[63:32];
        end else if (r_len_ok && r_pad_idx == LEN_LO_WORD) begin
            pad_word = r_total[31:0];
        end else begin
            pad_word = '0;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_fill[5:2];
        ram_wdata = {r_acc, i_in.data_byte};
        ram_raddr = '0;
        if (r_state == S_PAD) begin
            ram_we    = 1'b1;
            ram_waddr = r_pad_idx;
            ram_wdata = pad_word;
        end else if (r_state == S_IDLE) begin
            ram_we = in_acc && (i_in.action == ACT_ABSORB) && (r_fill[1:0] == 2'd3);
        end else if (r_state == S_ROUND) begin
            // registered read: fetch the word for the next round
            ram_raddr = r_rnd[3:0] + 4'd1;
        end
    end

    sha_ram #(
        .WIDTH (32),
        .DEPTH (BUF_WORDS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rnd_ctl.mem_word = (r_rnd[5:4] == 2'd0);
    assign rnd_ctl.k        = K_TAB[r_rnd];

    sha_round u_round (
        .i_vars     (r_vars),
        .i_sched    (r_sched),
        .i_mem_word (ram_rdata),
        .i_ctl      (rnd_ctl),
        .o_vars     (rnd_vars),
        .o_w        (rnd_w)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.action == ACT_FINISH) begin
                        n_state = S_PAD;
                    end else if (r_fill == FILL_LAST) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_PAD: begin
                if (r_pad_idx == LEN_LO_WORD) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (r_rnd == RND_LAST) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (!r_final) begin
                    n_state = S_IDLE;
                end else if (r_more) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_acc && r_out_idx == WORD_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake and payload outputs
    always_comb begin
        i_in.ready        = (r_state == S_IDLE);
        o_out.valid       = (r_state == S_EMIT);
        o_out.word_index  = r_out_idx;
        o_out.digest_word = r_chain[r_out_idx];
        o_out.last_word   = (r_out_idx == WORD_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_bits    <= '0;
            r_chain   <= IV;
            r_out_idx <= '0;
            r_final   <= 1'b0;
            r_more    <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.action == ACT_ABSORB) begin
                            r_acc   <= {r_acc[15:0], i_in.data_byte};
                            r_fill  <= r_fill + 6'd1;
                            r_final <= 1'b0;
                        end else begin
                            r_final   <= 1'b1;
                            r_total   <= r_bits + {55'd0, r_fill, 3'd0};
                            r_pad_idx <= r_fill[5:2];
                            r_part    <= 1'b1;
                            r_len_ok  <= (r_fill < LEN_POS);
                            r_more    <= (r_fill >= LEN_POS);
                        end
                    end
                end
                S_PAD: begin
                    r_part    <= 1'b0;
                    r_pad_idx <= r_pad_idx + 4'd1;
                end
                S_LOAD: begin
                    r_vars <= r_chain;
                    r_rnd  <= '0;
                end
                S_ROUND: begin
                    r_vars  <= rnd_vars;
                    r_sched <= {r_sched[1:15], rnd_w};
                    r_rnd   <= r_rnd + 6'd1;
                end
                S_UPDATE: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_vars[i];
                    end
                    if (!r_final) begin
                        r_bits <= r_bits + BLOCK_BITS;
                    end else if (r_more) begin
                        // second padding block: zeros then the length
                        r_more    <= 1'b0;
                        r_len_ok  <= 1'b1;
                        r_pad_idx <= '0;
                        r_part    <= 1'b0;
                    end
                end
                S_EMIT: begin
                    if (out_acc) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == WORD_LAST) begin
                            r_chain <= IV;
                            r_fill  <= '0;
                            r_bits  <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while digest is being emitted");

    a_no_write_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> !ram_we)
        else $error("block buffer written during compression");

    a_full_block_compresses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.action == ACT_ABSORB && r_fill == FILL_LAST) |=>
        (r_state == S_LOAD && r_fill == 6'd0))
        else $error("full block did not start a compression");

    a_restart_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.last_word) |=>
        (r_fill == 6'd0 && r_bits == 64'd0 && r_chain == IV && r_state == S_IDLE))
        else $error("engine not re-initialized after the last digest word");
`endif

endmodule

// ===== tb/sv/sha256_hash_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_hash_tb
// Byte-serial SHA-256 engine check: messages of varied length are fed one
// byte per item and closed with a finish item. A software hash predicts the
// eight digest words of each finish, and every output item is compared with
// the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_hash_tb;

    import sha_pkg::ACT_ABSORB;
    import sha_pkg::ACT_FINISH;

    localparam int WDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 200;
    localparam int RAND_ITEMS = 400;

    localparam bit [31:0] HASH_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic       act;
        logic [7:0] data;
        bit         hold;   // wait for every pending digest word first
    } byte_item_t;

    typedef struct {
        logic [2:0]  idx;
        logic [31:0] word;
        logic        last;
    } digest_item_t;

    logic i_clk;
    logic i_rst_n;

    sha_in_if  in_if();
    sha_out_if out_if();

    sha256_hash u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    byte_item_t   feed_q[$];
    digest_item_t digest_q[$];

    // software hash state
    logic [31:0] hash_val [8];
    logic [7:0]  blk_buf [64];
    int          blk_fill;
    logic [63:0] msg_bits;

    int n_total;
    int n_issued;
    int n_accepted;
    int err_count;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.action = ACT_ABSORB;
        in_if.data_byte = 8'h00;
        out_if.ready = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 8; i++) hash_val[i] = HASH_INIT[i];
        blk_fill = 0;
        msg_bits = 64'd0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, s0, s1, t1, t2;
        for (int i = 0; i < 8; i++) v[i] = hash_val[i];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wt = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
            end else begin
                s0 = rotr(w[(r-15)&15], 7) ^ rotr(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
                s1 = rotr(w[(r-2)&15], 17) ^ rotr(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
                wt = s1 + w[(r-7)&15] + s0 + w[r&15];
            end
            w[r&15] = wt;
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_val[i] = hash_val[i] + v[i];
    endfunction

    // advance the software hash by one accepted item
    function automatic void hash_accept(logic act, logic [7:0] b);
        logic [63:0] total;
        digest_item_t d;
        if (act == ACT_ABSORB) begin
            blk_buf[blk_fill] = b;
            blk_fill++;
            if (blk_fill == 64) begin
                compress_block();
                msg_bits = msg_bits + 64'd512;
                blk_fill = 0;
            end
        end else begin
            total = msg_bits + (64'(blk_fill) << 3);
            blk_buf[blk_fill] = 8'h80;
            for (int i = blk_fill + 1; i < 64; i++) blk_buf[i] = 8'h00;
            // no room for the length: extra block
            if (blk_fill >= 56) begin
                compress_block();
                for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) blk_buf[56+i] = total[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                d.idx = 3'(i);
                d.word = hash_val[i];
                d.last = (i == 7);
                digest_q.push_back(d);
            end
            hash_restart();
        end
    endfunction

    function automatic int pace_phase();
        int p;
        if (n_total == 0) return 0;
        p = (n_issued * 3) / n_total;
        return (p > 2) ? 2 : p;
    endfunction

    function automatic int send_idle_pct();
        case (pace_phase())
            0: return 16;
            1: return 64;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (pace_phase())
            0: return 64;
            1: return 16;
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < 50) $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic add_item(logic act, logic [7:0] data, bit hold);
        byte_item_t it;
        it.act = act;
        it.data = data;
        it.hold = hold;
        feed_q.push_back(it);
    endtask

    // random bytes of the given length, then a finish with a junk byte
    task automatic add_message(int len, bit hold);
        for (int i = 0; i < len; i++)
            add_item(ACT_ABSORB, 8'($urandom_range(255)), hold && i == 0);
        add_item(ACT_FINISH, 8'($urandom_range(255)), hold && len == 0);
    endtask

    function automatic int pick_length();
        int sizes [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        if ($urandom_range(99) < 70) return $urandom_range(20);
        return sizes[$urandom_range(9)];
    endfunction

    // driver
    always @(posedge i_clk) begin
        bit take;
        byte_item_t nx;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                hash_accept(in_if.action, in_if.data_byte);
                n_accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                take = feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct();
                if (take && feed_q[0].hold && digest_q.size() != 0) take = 1'b0;
                if (take) begin
                    nx = feed_q.pop_front();
                    in_if.action <= nx.act;
                    in_if.data_byte <= nx.data;
                    n_issued++;
                end
                in_if.valid <= take;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        digest_item_t e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected digest word idx=%0d data=%08h",
                                              out_if.word_index, out_if.digest_word));
                end else begin
                    e = digest_q.pop_front();
                    if (out_if.word_index !== e.idx)
                        report_mismatch($sformatf("word_index got %0d want %0d",
                                                  out_if.word_index, e.idx));
                    if (out_if.digest_word !== e.word)
                        report_mismatch($sformatf("digest_word[%0d] got %08h want %08h",
                                                  e.idx, out_if.digest_word, e.word));
                    if (out_if.last_word !== e.last)
                        report_mismatch($sformatf("last_word[%0d] got %b want %b",
                                                  e.idx, out_if.last_word, e.last));
                end
            end
            out_if.ready <= $urandom_range(99) >= recv_idle_pct();
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int len;
        n_total = 0;
        n_issued = 0;
        n_accepted = 0;
        err_count = 0;
        idle_cycles = 0;
        hash_restart();

        // empty message, then again with a junk byte on the finish
        add_item(ACT_FINISH, 8'h00, 1'b0);
        add_item(ACT_FINISH, 8'hff, 1'b0);
        // "abc"
        add_item(ACT_ABSORB, 8'h61, 1'b0);
        add_item(ACT_ABSORB, 8'h62, 1'b0);
        add_item(ACT_ABSORB, 8'h63, 1'b0);
        add_item(ACT_FINISH, 8'h5a, 1'b0);
        // byte extremes
        add_item(ACT_ABSORB, 8'h00, 1'b0);
        add_item(ACT_FINISH, 8'h00, 1'b0);
        add_item(ACT_ABSORB, 8'hff, 1'b0);
        add_item(ACT_FINISH, 8'hff, 1'b0);
        add_item(ACT_ABSORB, 8'h80, 1'b0);
        add_item(ACT_ABSORB, 8'h7f, 1'b0);
        add_item(ACT_ABSORB, 8'h01, 1'b0);
        add_item(ACT_FINISH, 8'h80, 1'b0);
        add_item(ACT_ABSORB, 8'h55, 1'b0);
        add_item(ACT_ABSORB, 8'haa, 1'b0);
        add_item(ACT_FINISH, 8'h01, 1'b0);

        // random messages; the first one waits for the directed digests
        len = feed_q.size();
        add_message(pick_length(), 1'b1);
        while (feed_q.size() - len < RAND_ITEMS)
            add_message(pick_length(), $urandom_range(9) == 0);
        n_total = feed_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (n_accepted < n_total || digest_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (digest_q.size() != 0)
            report_mismatch($sformatf("%0d digest words never arrived", digest_q.size()));
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
